[sv/rhsc_pkg.sv]
// shared types and constants of the rolling hash substring count unit
package rhsc_pkg;

  // hash word and counter widths
  localparam int unsigned HASH_W = 64;
  localparam int unsigned CNT_W  = 21;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // character code subtracted before hashing
  localparam logic [7:0] CHAR_ZERO = 8'd48;

  // result queue geometry
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;
  localparam int unsigned FIFO_CW    = 4;

  // payload widths on the ports
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  // input item kinds
  typedef enum logic {
    KIND_PATTERN = 1'b0,
    KIND_TEXT    = 1'b1
  } kind_t;

  // one result item
  typedef struct packed {
    logic             match;
    logic [CNT_W-1:0] match_count;
    logic             done_res;
  } res_t;

endpackage

[sv/rolling_hash_substring_count_unit.sv]
// rolling hash substring count unit: base-33 window hash against a pattern hash
//
// Pattern characters (tuser = 0) build the pattern hash and the top power 33^(m-1);
// text characters (tuser = 1) run through a delay line of the last m characters
// and a rolling window hash, and each yields one result item with the match flag
// and the running match count of the current text. One item is taken every
// cycle while in_tready is high; a text item's result passes the delay-line read
// with the item, the 64x13 multiply, the subtract, the window update and the
// compare into the result queue before the queue puts it out. An eight-entry
// result queue with a credit count stands between the two sides: in_tready
// drops only while eight results are in flight or waiting downstream.
// The MAX_PATTERN x 8 delay line is read and, if m != 0, written once per text item.
module rolling_hash_substring_count_unit
  import rhsc_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input items
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] ch, [8] first, rest zero
  input  logic                   in_tuser,   // [0] kind
  input  logic                   in_tlast,   // last
  // result items
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] match, [21:1] match_count, rest zero
  output logic                   out_tlast   // done_res
);

  localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

  // input field decode
  logic       in_acc;
  logic [7:0] in_ch;
  logic       in_first;
  kind_t      in_kind;

  assign in_acc   = in_tvalid && in_tready;
  assign in_ch    = in_tdata[7:0];
  assign in_first = in_tdata[8];
  assign in_kind  = kind_t'(in_tuser);

  // pattern state
  logic [HASH_W-1:0] ph_r, ph_nxt;
  logic [HASH_W-1:0] tp_r, tp_nxt;
  logic [LW-1:0]     plen_r, plen_nxt;

  // text control state
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;

  // credit and result queue state
  logic [FIFO_CW-1:0] cred_r, cred_nxt;
  logic [FIFO_CW-1:0] fcnt_r, fcnt_nxt;
  logic [FIFO_AW-1:0] wp_r, rp_r;
  res_t               fifo_r [FIFO_DEPTH];

  // pipeline registers
  logic              s1_v_r, s1_first_r, s1_last_r, s1_sub_r, s1_full_r;
  logic [7:0]        s1_ch_r;
  logic [HASH_W-1:0] s1_tp_r, s1_ph_r;
  logic [7:0]        rd_q_r;

  logic              s2_v_r, s2_first_r, s2_last_r, s2_full_r, s2_neg_r;
  logic [8:0]        s2_cv_r;
  logic [HASH_W-1:0] s2_prod_r, s2_ph_r;

  logic              s3_v_r, s3_first_r, s3_last_r, s3_full_r;
  logic [HASH_W-1:0] s3_d_r, s3_ph_r;

  logic              s4_v_r, s4_first_r, s4_last_r, s4_full_r;
  logic [HASH_W-1:0] s4_ph_r;
  logic [HASH_W-1:0] wh_r, wh_nxt;
  logic [CNT_W-1:0]  hit_r, hit_nxt;

  // delay line
  logic [7:0] dline [MAX_PATTERN];

  // pattern hash and top power update
  logic [HASH_W-1:0] ph_base, tp_base, ch_cv64;
  logic [LW-1:0]     plen_base;

  always_comb begin
    ph_base   = in_first ? '0 : ph_r;
    tp_base   = in_first ? HASH_W'(1) : tp_r;
    plen_base = in_first ? '0 : plen_r;
    ch_cv64   = HASH_W'(in_ch) - HASH_W'(CHAR_ZERO);
    ph_nxt    = ph_r;
    tp_nxt    = tp_r;
    plen_nxt  = plen_r;
    if (in_acc && in_kind == KIND_PATTERN) begin
      ph_nxt   = ph_base;
      tp_nxt   = tp_base;
      plen_nxt = plen_base;
      if (plen_base < LW'(MAX_PATTERN)) begin
        ph_nxt   = (ph_base << 5) + ph_base + ch_cv64;
        tp_nxt   = (plen_base != '0) ? (tp_base << 5) + tp_base : tp_base;
        plen_nxt = plen_base + LW'(1);
      end
    end
  end

  // text item control: window pointer and seen count
  logic             txt_acc, m_nz, sub_en, full_en;
  logic [CNT_W-1:0] seen_base, seen_inc;
  logic [AW-1:0]    ptr_base, ptr_use;
  logic [LW-1:0]    ptr_inc;

  always_comb begin
    txt_acc   = in_acc && in_kind == KIND_TEXT;
    m_nz      = plen_r != '0;
    seen_base = in_first ? '0 : seen_r;
    ptr_base  = in_first ? '0 : ptr_r;
    ptr_use   = (LW'(ptr_base) >= plen_r) ? '0 : ptr_base;
    ptr_inc   = LW'(ptr_use) + LW'(1);
    sub_en    = m_nz && seen_base >= CNT_W'(plen_r);
    seen_inc  = (seen_base == CNT_MAX) ? seen_base : seen_base + CNT_W'(1);
    full_en   = m_nz && seen_inc >= CNT_W'(plen_r);
    seen_nxt  = seen_r;
    ptr_nxt   = ptr_r;
    if (txt_acc) begin
      seen_nxt = seen_inc;
      if (m_nz) begin
        ptr_nxt = (ptr_inc >= plen_r) ? '0 : AW'(ptr_inc);
      end else begin
        ptr_nxt = ptr_base;
      end
    end
  end

  // delay line: old character read out before the new one lands
  always_ff @(posedge clk) begin
    rd_q_r <= dline[ptr_use];
    if (txt_acc && m_nz) begin
      dline[ptr_use] <= in_ch;
    end
  end

  // stage 1: scale the leaving character by 33 and multiply by the top power
  logic [7:0]        old_mag;
  logic              old_neg;
  logic [12:0]       k_mag;
  logic [HASH_W-1:0] prod;
  logic [8:0]        s1_cv;

  always_comb begin
    old_neg = rd_q_r < CHAR_ZERO;
    old_mag = old_neg ? CHAR_ZERO - rd_q_r : rd_q_r - CHAR_ZERO;
    k_mag   = s1_sub_r ? (13'(old_mag) << 5) + 13'(old_mag) : '0;
    prod    = s1_tp_r * HASH_W'(k_mag);
    s1_cv   = {1'b0, s1_ch_r} - {1'b0, CHAR_ZERO};
  end

  // stage 2: new character value minus the leaving term
  logic [HASH_W-1:0] cv_ext, d_val;

  always_comb begin
    cv_ext = {{(HASH_W-9){s2_cv_r[8]}}, s2_cv_r};
    d_val  = s2_neg_r ? cv_ext + s2_prod_r : cv_ext - s2_prod_r;
  end

  // stage 3: window hash times 33 plus the difference
  logic [HASH_W-1:0] wh_base;

  always_comb begin
    wh_base = s3_first_r ? '0 : wh_r;
    wh_nxt  = s3_v_r ? (wh_base << 5) + wh_base + s3_d_r : wh_r;
  end

  // stage 4: compare against the pattern hash and count hits
  logic             hit_now;
  logic [CNT_W-1:0] hit_base;
  res_t             res_w;

  always_comb begin
    hit_now  = s4_full_r && wh_r == s4_ph_r;
    hit_base = s4_first_r ? '0 : hit_r;
    hit_nxt  = hit_r;
    if (s4_v_r) begin
      hit_nxt = (hit_now && hit_base != CNT_MAX) ? hit_base + CNT_W'(1) : hit_base;
    end
    res_w.match       = hit_now;
    res_w.match_count = hit_nxt;
    res_w.done_res    = s4_last_r;
  end

  // result queue and credits
  logic out_pop;

  assign out_pop    = out_tvalid && out_tready;
  assign out_tvalid = fcnt_r != '0;
  assign in_tready  = cred_r < FIFO_CW'(FIFO_DEPTH);
  assign out_tdata  = {{(OUT_TDATA_W-CNT_W-1){1'b0}},
                       fifo_r[rp_r].match_count, fifo_r[rp_r].match};
  assign out_tlast  = fifo_r[rp_r].done_res;

  always_comb begin
    cred_nxt = cred_r;
    if (txt_acc && !out_pop) begin
      cred_nxt = cred_r + FIFO_CW'(1);
    end else if (!txt_acc && out_pop) begin
      cred_nxt = cred_r - FIFO_CW'(1);
    end
    fcnt_nxt = fcnt_r;
    if (s4_v_r && !out_pop) begin
      fcnt_nxt = fcnt_r + FIFO_CW'(1);
    end else if (!s4_v_r && out_pop) begin
      fcnt_nxt = fcnt_r - FIFO_CW'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      tp_r   <= HASH_W'(1);
      plen_r <= '0;
      seen_r <= '0;
      ptr_r  <= '0;
      wh_r   <= '0;
      hit_r  <= '0;
      cred_r <= '0;
      fcnt_r <= '0;
      wp_r   <= '0;
      rp_r   <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      tp_r   <= tp_nxt;
      plen_r <= plen_nxt;
      seen_r <= seen_nxt;
      ptr_r  <= ptr_nxt;
      wh_r   <= wh_nxt;
      hit_r  <= hit_nxt;
      cred_r <= cred_nxt;
      fcnt_r <= fcnt_nxt;
      if (s4_v_r) begin
        wp_r <= wp_r + FIFO_AW'(1);
      end
      if (out_pop) begin
        rp_r <= rp_r + FIFO_AW'(1);
      end
      s1_v_r <= txt_acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_first_r <= in_first;
    s1_last_r  <= in_tlast;
    s1_sub_r   <= sub_en;
    s1_full_r  <= full_en;
    s1_ch_r    <= in_ch;
    s1_tp_r    <= tp_r;
    s1_ph_r    <= ph_r;

    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_full_r  <= s1_full_r;
    s2_neg_r   <= old_neg;
    s2_cv_r    <= s1_cv;
    s2_prod_r  <= prod;
    s2_ph_r    <= s1_ph_r;

    s3_first_r <= s2_first_r;
    s3_last_r  <= s2_last_r;
    s3_full_r  <= s2_full_r;
    s3_d_r     <= d_val;
    s3_ph_r    <= s2_ph_r;

    s4_first_r <= s3_first_r;
    s4_last_r  <= s3_last_r;
    s4_full_r  <= s3_full_r;
    s4_ph_r    <= s3_ph_r;

    if (s4_v_r) begin
      fifo_r[wp_r] <= res_w;
    end
  end

  // credits never exceed the queue depth
  a_cred_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("credit count beyond queue depth");

  // queued results are always covered by credits
  a_fcnt_le_cred: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= cred_r)
    else $error("result queue holds more than the credits allow");

  // a result never arrives at a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> fcnt_r < FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  // a match leaves a non-zero hit count
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && hit_now) |=> hit_r != '0)
    else $error("match not counted");

endmodule

[test/rhsc_match_checker.sv]
// checker for the rolling hash substring count unit: predicts and compares result items
`timescale 1ns / 1ps

module rhsc_match_checker
  import rhsc_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  output int unsigned            fail_count,
  output int unsigned            results_owed
);

  localparam logic [HASH_W-1:0] HASH_BASE = 64'd33;

  // predicted state of the unit
  logic [HASH_W-1:0] pat_hash;
  logic [HASH_W-1:0] top_pow;
  logic [HASH_W-1:0] win_hash;
  logic [10:0]       pat_len;
  logic [7:0]        delay_line [MAX_PATTERN];
  logic [CNT_W-1:0]  chars_seen;
  logic [CNT_W-1:0]  hit_cnt;
  int unsigned       line_ptr;

  // result items still owed by the unit, oldest first
  res_t owed_q[$];
  res_t head_res;

  // character value, wrapping in 64 bits below '0'
  function automatic logic [HASH_W-1:0] char_val(logic [7:0] c);
    return {56'd0, c} - {56'd0, CHAR_ZERO};
  endfunction

  task automatic clear_model();
    pat_hash   = '0;
    top_pow    = 64'd1;
    win_hash   = '0;
    pat_len    = '0;
    chars_seen = '0;
    hit_cnt    = '0;
    line_ptr   = 0;
    for (int i = 0; i < MAX_PATTERN; i++) delay_line[i] = 8'd0;
    owed_q.delete();
  endtask

  // advance the model by one accepted item; text items owe one result
  task automatic hash_step(kind_t kind, logic [7:0] ch, logic first, logic last);
    res_t        r;
    int unsigned m;
    if (kind == KIND_PATTERN) begin
      if (first) begin
        pat_hash = '0;
        pat_len  = '0;
        top_pow  = 64'd1;
      end
      // characters past the store are dropped
      if (pat_len < MAX_PATTERN) begin
        pat_hash = pat_hash * HASH_BASE + char_val(ch);
        if (pat_len != 0) top_pow = top_pow * HASH_BASE;
        pat_len++;
      end
    end else begin
      if (first) begin
        win_hash   = '0;
        chars_seen = '0;
        hit_cnt    = '0;
        line_ptr   = 0;
      end
      m = 32'(pat_len);
      if (m == 0) begin
        win_hash = win_hash * HASH_BASE + char_val(ch);
      end else begin
        if (line_ptr >= m) line_ptr = 0;
        // drop the oldest character once the window is full
        if (chars_seen >= m) win_hash = win_hash - top_pow * char_val(delay_line[line_ptr]);
        win_hash = win_hash * HASH_BASE + char_val(ch);
        delay_line[line_ptr] = ch;
        line_ptr = (line_ptr + 1 >= m) ? 0 : line_ptr + 1;
      end
      if (chars_seen != CNT_MAX) chars_seen++;
      r.match = 1'b0;
      if (m != 0 && chars_seen >= m && win_hash == pat_hash) begin
        r.match = 1'b1;
        if (hit_cnt != CNT_MAX) hit_cnt++;
      end
      r.match_count = hit_cnt;
      r.done_res    = last;
      owed_q.insert(owed_q.size(), r);
    end
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready)
        hash_step(kind_t'(in_tuser), in_tdata[7:0], in_tdata[8], in_tlast);
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          $error("result item with none owed: match %0d, match_count %0d, done_res %0d",
                 out_tdata[0], out_tdata[21:1], out_tlast);
          fail_count++;
        end else begin
          head_res = owed_q.pop_front();
          if (out_tdata[0] !== head_res.match) begin
            $error("match mismatch: expected %0d, got %0d", head_res.match, out_tdata[0]);
            fail_count++;
          end
          if (out_tdata[21:1] !== head_res.match_count) begin
            $error("match_count mismatch: expected %0d, got %0d",
                   head_res.match_count, out_tdata[21:1]);
            fail_count++;
          end
          if (out_tlast !== head_res.done_res) begin
            $error("done_res mismatch: expected %0d, got %0d", head_res.done_res, out_tlast);
            fail_count++;
          end
        end
      end
    end
    results_owed = owed_q.size();
  end

endmodule

[test/rolling_hash_substring_count_unit_tb.sv]
// testbench top of the rolling hash substring count unit: stimulus, flow control and verdict
`timescale 1ns / 1ps

module rolling_hash_substring_count_unit_tb;
  import rhsc_pkg::*;

  localparam int unsigned MAX_PAT     = 1024;
  localparam int unsigned RAND_ITEMS  = 1800;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 16;

  // characters used to build searches
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] CH_DIGIT = 8'h30;
  localparam logic [7:0] CH_LOW   = 8'h00;
  localparam logic [7:0] CH_HIGH  = 8'hff;

  // alphabets for random characters
  localparam int unsigned ALPHA_AB     = 0;
  localparam int unsigned ALPHA_BYTE   = 1;
  localparam int unsigned ALPHA_DIGITS = 2;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  int unsigned            fail_count;
  int unsigned            results_owed;

  // what the stimulus knows of the unit, to keep delay-line reads on written entries
  int unsigned pat_len_s;
  int unsigned written_hi;
  int unsigned text_len_s;
  bit          pat_dirty;
  logic [7:0]  pat_buf [MAX_PAT];
  int unsigned items_sent;
  int unsigned bulk_items;
  int unsigned cycle_cnt;
  bit          in_burst;
  bit          out_burst;

  rolling_hash_substring_count_unit #(
    .MAX_PATTERN(MAX_PAT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  rhsc_match_checker #(
    .MAX_PATTERN(MAX_PAT)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .results_owed(results_owed)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[rolling_hash_substring_count_unit] ERROR");
      $finish;
    end
  end

  // result side: random stall before each item, none in burst stretches
  initial begin : sink_side
    int unsigned stall;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic logic [7:0] pick_char(int unsigned alpha);
    case (alpha)
      ALPHA_AB:     return $urandom_range(0, 1) ? CH_B : CH_A;
      ALPHA_DIGITS: return CH_DIGIT + 8'($urandom_range(0, 3));
      default:      return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // drive one item after a random gap and hold it until taken
  task automatic push_item(kind_t kind, logic [7:0] ch, logic first, logic last);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_TDATA_W'({first, ch});
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic pattern_char(logic [7:0] ch, logic first, logic last);
    if (first) pat_len_s = 0;
    if (pat_len_s < MAX_PAT) begin
      pat_buf[pat_len_s] = ch;
      pat_len_s++;
    end
    pat_dirty = 1'b1;
    push_item(KIND_PATTERN, ch, first, last);
  endtask

  // a text that outlives a longer pattern must restart, or unwritten entries get read
  task automatic text_char(logic [7:0] ch, logic first, logic last);
    logic start;
    start = first || (pat_dirty && pat_len_s > written_hi);
    if (start) text_len_s = 0;
    pat_dirty = 1'b0;
    text_len_s++;
    if (pat_len_s != 0)
      written_hi = (written_hi > ((text_len_s < pat_len_s) ? text_len_s : pat_len_s)) ?
                   written_hi : ((text_len_s < pat_len_s) ? text_len_s : pat_len_s);
    push_item(KIND_TEXT, ch, start, last);
  endtask

  // one search: a pattern, then a text that often holds copies of it
  task automatic run_search();
    int unsigned plen;
    int unsigned tlen;
    int unsigned alpha;
    int unsigned copy_pos;
    int unsigned pick;
    bit          copying;
    bit          extend;
    bit          carry_on;
    logic [7:0]  ch;
    in_burst  = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
    alpha = $urandom_range(0, 2);
    pick  = $urandom_range(0, 9);
    if (pick < 6)      plen = $urandom_range(1, 4);
    else if (pick < 9) plen = $urandom_range(5, 12);
    else               plen = $urandom_range(13, 40);
    // now and then grow the previous pattern instead of starting afresh
    extend = (pat_len_s != 0) && ($urandom_range(0, 9) == 0);
    for (int k = 0; k < plen; k++)
      pattern_char(pick_char(alpha), (k == 0) && !extend, 1'($urandom_range(0, 1)));
    tlen     = $urandom_range(1, 48);
    carry_on = ($urandom_range(0, 9) == 0);
    copying  = 1'b0;
    copy_pos = 0;
    for (int k = 0; k < tlen; k++) begin
      // swap in a short pattern halfway through the text
      if (k == tlen / 2 && k != 0 && $urandom_range(0, 7) == 0) begin
        plen = $urandom_range(1, 4);
        for (int j = 0; j < plen; j++)
          pattern_char(pick_char(alpha), j == 0, 1'b0);
        copying = 1'b0;
      end
      if (!copying && $urandom_range(0, 2) == 0) begin
        copying  = 1'b1;
        copy_pos = 0;
      end
      if (copying) begin
        ch = pat_buf[copy_pos];
        copy_pos++;
        if (copy_pos >= pat_len_s) copying = 1'b0;
      end else begin
        ch = pick_char(alpha);
      end
      text_char(ch, (k == 0) && !carry_on, (k == tlen - 1) && ($urandom_range(0, 7) != 0));
    end
  endtask

  // pattern longer than the store, then a text that ends in a copy of the kept part
  task automatic run_overflow();
    in_burst  = 1'b0;
    out_burst = ($urandom_range(0, 1) == 0);
    for (int k = 0; k < MAX_PAT + 3; k++)
      pattern_char(pick_char(ALPHA_AB), k == 0, 1'b0);
    text_char(pick_char(ALPHA_AB), 1'b1, 1'b0);
    text_char(pick_char(ALPHA_AB), 1'b0, 1'b0);
    for (int k = 0; k < MAX_PAT; k++)
      text_char(pat_buf[k], 1'b0, k == MAX_PAT - 1);
  endtask

  // stimulus and verdict
  initial begin : source_side
    bit          overflow_done;
    in_tvalid  = 1'b0;
    in_tuser   = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    rst_n      = 1'b0;
    pat_len_s  = 0;
    written_hi = 0;
    text_len_s = 0;
    pat_dirty  = 1'b0;
    items_sent = 0;
    in_burst   = 1'b0;
    out_burst  = 1'b0;
    overflow_done = 1'b0;
    for (int i = 0; i < MAX_PAT; i++) pat_buf[i] = 8'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // text with an empty pattern never matches
    text_char(CH_DIGIT, 1'b1, 1'b0);
    text_char(CH_LOW, 1'b0, 1'b0);
    text_char(CH_HIGH, 1'b0, 1'b1);
    // last on a pattern character is ignored; two hits
    pattern_char(CH_A, 1'b1, 1'b1);
    pattern_char(CH_B, 1'b0, 1'b0);
    text_char(CH_X, 1'b1, 1'b0);
    text_char(CH_A, 1'b0, 1'b0);
    text_char(CH_B, 1'b0, 1'b0);
    text_char(CH_A, 1'b0, 1'b0);
    text_char(CH_B, 1'b0, 1'b1);
    // extreme bytes, below '0' wraps
    pattern_char(CH_HIGH, 1'b1, 1'b0);
    pattern_char(CH_LOW, 1'b0, 1'b0);
    text_char(CH_HIGH, 1'b1, 1'b0);
    text_char(CH_LOW, 1'b0, 1'b0);
    text_char(CH_HIGH, 1'b0, 1'b0);
    text_char(CH_LOW, 1'b0, 1'b1);
    // pattern shrinks in the middle of a text
    pattern_char(CH_A, 1'b1, 1'b0);
    pattern_char(CH_B, 1'b0, 1'b0);
    pattern_char(CH_C, 1'b0, 1'b0);
    text_char(CH_A, 1'b1, 1'b0);
    text_char(CH_B, 1'b0, 1'b0);
    text_char(CH_C, 1'b0, 1'b0);
    pattern_char(CH_C, 1'b1, 1'b0);
    text_char(CH_C, 1'b0, 1'b0);
    text_char(CH_Z, 1'b0, 1'b1);

    // random searches, one overflow case among them
    bulk_items = items_sent;
    while (items_sent - bulk_items < RAND_ITEMS) begin
      if (!overflow_done && items_sent - bulk_items > RAND_ITEMS / 3) begin
        run_overflow();
        overflow_done = 1'b1;
      end else begin
        run_search();
      end
    end
    in_tvalid <= 1'b0;
    out_burst = 1'b0;

    // drain what is still owed
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("[rolling_hash_substring_count_unit] OK");
    else
      $display("[rolling_hash_substring_count_unit] ERROR");
    $finish;
  end

endmodule

[filelist.f]
sv/rhsc_pkg.sv
sv/rolling_hash_substring_count_unit.sv
test/rhsc_match_checker.sv
test/rolling_hash_substring_count_unit_tb.sv
